[hdl/rau_pkg.sv]
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int IN_W          = 32;
    localparam int DATA_W        = 64;
    localparam int SLICE_W       = 16;
    localparam int N_CELLS       = DATA_W / SLICE_W;
    localparam int CNT_W         = 6;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_SUB   = 3'd1;
    localparam logic [2:0] CMD_MUL   = 3'd2;
    localparam logic [2:0] CMD_DIV   = 3'd3;
    localparam logic [2:0] CMD_CMP   = 3'd4;
    localparam logic [2:0] CMD_SET   = 3'd5;
    localparam logic [2:0] CMD_MIXED = 3'd6;
    localparam logic [2:0] CMD_NONE  = 3'd7;

    localparam logic [2:0] REL_LT = 3'd0;
    localparam logic [2:0] REL_LE = 3'd1;
    localparam logic [2:0] REL_EQ = 3'd2;
    localparam logic [2:0] REL_NE = 3'd3;
    localparam logic [2:0] REL_GT = 3'd4;
    localparam logic [2:0] REL_GE = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_TWOS,
        ST_GCD,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cell_ctrl_t;

    // sign-extend the low OPERAND_WIDTH bits, one guard bit on top
    function automatic logic signed [IN_W:0] op_ext(input logic [IN_W-1:0] raw);
        logic signed [IN_W-1:0] t;
        t = $signed(raw << (IN_W - OPERAND_WIDTH)) >>> (IN_W - OPERAND_WIDTH);
        return {t[IN_W-1], t};
    endfunction

    function automatic logic [IN_W-1:0] mag_op(input logic signed [IN_W:0] x);
        logic signed [IN_W:0] t;
        t = x[IN_W] ? -x : x;
        return t[IN_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] mag_wide(input logic signed [DATA_W-1:0] x);
        return x[DATA_W-1] ? -x : x;
    endfunction

endpackage

[hdl/rational_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
// Compare, unknown and zero-part results go from input transfer through ST_MUL and ST_PREP
// to ST_DONE; others also pass the shared factor-of-two shifts, binary GCD steps, divider and ST_FIN.
// Throughput: one item at a time; the next transfer is taken once the result is
// in the output register. Set by the GCD loop and the 64-step divider cell rows.
// Reset: aresetn, synchronous, active low, clears control state and m_valid.
module rational_arithmetic_unit_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_command,
    input  logic signed [31:0]  s_a_num,
    input  logic signed [31:0]  s_a_den,
    input  logic signed [31:0]  s_b_num,
    input  logic signed [31:0]  s_b_den,
    input  logic signed [31:0]  s_whole,
    input  logic [2:0]          s_relation,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [63:0]  m_res_num,
    output logic [62:0]         m_res_den,
    output logic                m_compare_true,
    output logic                m_zero_denominator
);

    localparam int W  = rau_pkg::IN_W;
    localparam int DW = rau_pkg::DATA_W;

    rau_pkg::state_t state_reg, state_next;

    logic [2:0]              cmd_reg, rel_reg;
    logic signed [W:0]       an_reg, ad_reg, bn_reg, bd_reg, w_reg;
    logic signed [DW-1:0]    p0_reg, p1_reg, p2_reg;
    logic                    neg_reg;
    logic [DW-1:0]           u_reg, v_reg, nn_reg, dd_reg;
    logic [rau_pkg::CNT_W-1:0] cnt_reg;
    logic [DW-1:0]           rnum_reg;
    logic [DW-2:0]           rden_reg;
    logic                    rcmp_reg, rzd_reg;
    logic                    m_valid_reg;
    logic signed [DW-1:0]    m_res_num_reg;
    logic [DW-2:0]           m_res_den_reg;
    logic                    m_cmp_reg, m_zd_reg;

    logic signed [W:0]       m0a, m0b;
    logic signed [2*W+1:0]   prod0, prod1, prod2;
    logic signed [DW:0]      sum_s;
    logic [DW:0]             sum_m;
    logic                    prep_neg, prep_direct, cmp_r;
    logic [DW-1:0]           prep_n, prep_d;
    logic [DW-1:0]           q0, q1;
    logic                    out_load, u_gt_v;
    rau_pkg::cell_ctrl_t     dctrl;

    assign s_ready = (state_reg == rau_pkg::ST_IDLE);
    assign out_load = (state_reg == rau_pkg::ST_DONE) && (!m_valid_reg || m_ready);
    assign u_gt_v = u_reg > v_reg;

    always_comb begin
        if (cmd_reg == rau_pkg::CMD_MIXED) begin
            m0a = {1'b0, rau_pkg::mag_op(w_reg)};
            m0b = {1'b0, rau_pkg::mag_op(ad_reg)};
        end else begin
            m0a = an_reg;
            m0b = (cmd_reg == rau_pkg::CMD_MUL) ? bn_reg : bd_reg;
        end
    end

    assign prod0 = m0a * m0b;
    assign prod1 = ad_reg * bn_reg;
    assign prod2 = bd_reg * ad_reg;

    assign sum_s = {p0_reg[DW-1], p0_reg} +
                   ((cmd_reg == rau_pkg::CMD_SUB) ? -{p1_reg[DW-1], p1_reg}
                                                  : {p1_reg[DW-1], p1_reg});
    assign sum_m = sum_s[DW] ? -sum_s : sum_s;

    always_comb begin
        unique case (rel_reg)
            rau_pkg::REL_LT: cmp_r = p0_reg <  p1_reg;
            rau_pkg::REL_LE: cmp_r = p0_reg <= p1_reg;
            rau_pkg::REL_EQ: cmp_r = p0_reg == p1_reg;
            rau_pkg::REL_NE: cmp_r = p0_reg != p1_reg;
            rau_pkg::REL_GT: cmp_r = p0_reg >  p1_reg;
            rau_pkg::REL_GE: cmp_r = p0_reg >= p1_reg;
            default:         cmp_r = 1'b0;
        endcase
    end

    always_comb begin
        prep_neg    = 1'b0;
        prep_n      = '0;
        prep_d      = '0;
        prep_direct = 1'b1;
        unique case (cmd_reg)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                prep_neg    = sum_s[DW] ^ p2_reg[DW-1];
                prep_n      = sum_m[DW-1:0];
                prep_d      = rau_pkg::mag_wide(p2_reg);
                prep_direct = 1'b0;
            end
            rau_pkg::CMD_MUL: begin
                prep_neg    = p0_reg[DW-1] ^ p2_reg[DW-1];
                prep_n      = rau_pkg::mag_wide(p0_reg);
                prep_d      = rau_pkg::mag_wide(p2_reg);
                prep_direct = 1'b0;
            end
            rau_pkg::CMD_DIV: begin
                prep_neg    = p0_reg[DW-1] ^ p1_reg[DW-1];
                prep_n      = rau_pkg::mag_wide(p0_reg);
                prep_d      = rau_pkg::mag_wide(p1_reg);
                prep_direct = 1'b0;
            end
            rau_pkg::CMD_SET: begin
                prep_neg    = an_reg[W] ^ ad_reg[W];
                prep_n      = {{(DW-W){1'b0}}, rau_pkg::mag_op(an_reg)};
                prep_d      = {{(DW-W){1'b0}}, rau_pkg::mag_op(ad_reg)};
                prep_direct = 1'b0;
            end
            rau_pkg::CMD_MIXED: begin
                prep_neg    = w_reg[W] ^ an_reg[W] ^ ad_reg[W];
                prep_n      = p0_reg + {{(DW-W){1'b0}}, rau_pkg::mag_op(an_reg)};
                prep_d      = {{(DW-W){1'b0}}, rau_pkg::mag_op(ad_reg)};
                prep_direct = 1'b0;
            end
            default: prep_direct = 1'b1;
        endcase
        if (prep_n == '0 || prep_d == '0) begin
            prep_direct = 1'b1;
        end
    end

    always_comb begin
        dctrl.load = (state_reg == rau_pkg::ST_GCD) && (v_reg == '0);
        dctrl.step = (state_reg == rau_pkg::ST_DIV);
    end

    rau_divider u_div_num (
        .aclk     (aclk),
        .ctrl     (dctrl),
        .dividend (nn_reg),
        .divisor  (u_reg),
        .quotient (q0)
    );

    rau_divider u_div_den (
        .aclk     (aclk),
        .ctrl     (dctrl),
        .dividend (dd_reg),
        .divisor  (u_reg),
        .quotient (q1)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rau_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rau_pkg::ST_IDLE: if (s_valid) state_next = rau_pkg::ST_MUL;
            rau_pkg::ST_MUL:  state_next = rau_pkg::ST_PREP;
            rau_pkg::ST_PREP: state_next = prep_direct ? rau_pkg::ST_DONE : rau_pkg::ST_TWOS;
            rau_pkg::ST_TWOS: if (u_reg[0] | v_reg[0]) state_next = rau_pkg::ST_GCD;
            rau_pkg::ST_GCD:  if (v_reg == '0) state_next = rau_pkg::ST_DIV;
            rau_pkg::ST_DIV:  if (cnt_reg == '1) state_next = rau_pkg::ST_FIN;
            rau_pkg::ST_FIN:  state_next = rau_pkg::ST_DONE;
            rau_pkg::ST_DONE: if (!m_valid_reg || m_ready) state_next = rau_pkg::ST_IDLE;
            default:          state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_command;
            rel_reg <= s_relation;
            an_reg  <= rau_pkg::op_ext(s_a_num);
            ad_reg  <= rau_pkg::op_ext(s_a_den);
            bn_reg  <= rau_pkg::op_ext(s_b_num);
            bd_reg  <= rau_pkg::op_ext(s_b_den);
            w_reg   <= rau_pkg::op_ext(s_whole);
        end
        unique case (state_reg)
            rau_pkg::ST_MUL: begin
                p0_reg <= prod0[DW-1:0];
                p1_reg <= prod1[DW-1:0];
                p2_reg <= prod2[DW-1:0];
            end
            rau_pkg::ST_PREP: begin
                neg_reg  <= prep_neg;
                u_reg    <= prep_n;
                v_reg    <= prep_d;
                rcmp_reg <= (cmd_reg == rau_pkg::CMD_CMP) && cmp_r;
                if (cmd_reg == rau_pkg::CMD_CMP || cmd_reg == rau_pkg::CMD_NONE) begin
                    rnum_reg <= '0;
                    rden_reg <= '0;
                    rzd_reg  <= 1'b0;
                end else begin
                    if (prep_n == '0) begin
                        rnum_reg <= '0;
                    end else begin
                        rnum_reg <= prep_neg ? '1 : {{(DW-1){1'b0}}, 1'b1};
                    end
                    rden_reg <= {{(DW-2){1'b0}}, (prep_d != '0)};
                    rzd_reg  <= (prep_d == '0);
                end
            end
            rau_pkg::ST_TWOS: begin
                if (u_reg[0] | v_reg[0]) begin
                    nn_reg <= u_reg;
                    dd_reg <= v_reg;
                end else begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                end
            end
            rau_pkg::ST_GCD: begin
                cnt_reg <= '0;
                if (v_reg != '0) begin
                    priority if (!u_reg[0]) begin
                        u_reg <= u_reg >> 1;
                    end else if (!v_reg[0]) begin
                        v_reg <= v_reg >> 1;
                    end else if (u_gt_v) begin
                        u_reg <= (u_reg - v_reg) >> 1;
                    end else begin
                        v_reg <= (v_reg - u_reg) >> 1;
                    end
                end
            end
            rau_pkg::ST_DIV: cnt_reg <= cnt_reg + 1'b1;
            rau_pkg::ST_FIN: begin
                rnum_reg <= neg_reg ? -q0 : q0;
                rden_reg <= q1[DW-2:0];
                rcmp_reg <= 1'b0;
                rzd_reg  <= 1'b0;
            end
            default: ;
        endcase
        if (out_load) begin
            m_res_num_reg <= rnum_reg;
            m_res_den_reg <= rden_reg;
            m_cmp_reg     <= rcmp_reg;
            m_zd_reg      <= rzd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_res_num          = m_res_num_reg;
    assign m_res_den          = m_res_den_reg;
    assign m_compare_true     = m_cmp_reg;
    assign m_zero_denominator = m_zd_reg;

endmodule

[hdl/rau_cell.sv]
`timescale 1ns / 1ps

module rau_cell (
    input  logic                          aclk,
    input  rau_pkg::cell_ctrl_t           ctrl,
    input  logic                          take,
    input  logic [rau_pkg::SLICE_W-1:0]   load_q,
    input  logic [rau_pkg::SLICE_W-1:0]   d_slice,
    input  logic                          r_in,
    input  logic                          q_in,
    input  logic                          b_in,
    output logic                          r_out,
    output logic                          q_out,
    output logic                          b_out,
    output logic [rau_pkg::SLICE_W-1:0]   q_slice
);

    logic [rau_pkg::SLICE_W-1:0] r_reg;
    logic [rau_pkg::SLICE_W-1:0] q_reg;
    logic [rau_pkg::SLICE_W-1:0] shifted;
    logic [rau_pkg::SLICE_W:0]   diff;

    assign shifted = {r_reg[rau_pkg::SLICE_W-2:0], r_in};
    assign diff    = {1'b0, shifted} - {1'b0, d_slice} - {{rau_pkg::SLICE_W{1'b0}}, b_in};
    assign b_out   = diff[rau_pkg::SLICE_W];
    assign r_out   = r_reg[rau_pkg::SLICE_W-1];
    assign q_out   = q_reg[rau_pkg::SLICE_W-1];
    assign q_slice = q_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            r_reg <= '0;
            q_reg <= load_q;
        end else if (ctrl.step) begin
            r_reg <= take ? diff[rau_pkg::SLICE_W-1:0] : shifted;
            q_reg <= {q_reg[rau_pkg::SLICE_W-2:0], q_in};
        end
    end

endmodule

[hdl/rau_divider.sv]
`timescale 1ns / 1ps

module rau_divider (
    input  logic                         aclk,
    input  rau_pkg::cell_ctrl_t          ctrl,
    input  logic [rau_pkg::DATA_W-1:0]   dividend,
    input  logic [rau_pkg::DATA_W-1:0]   divisor,
    output logic [rau_pkg::DATA_W-1:0]   quotient
);

    logic [rau_pkg::N_CELLS-1:0] r_out;
    logic [rau_pkg::N_CELLS-1:0] q_out;
    logic [rau_pkg::N_CELLS-1:0] b_out;
    logic                        take;

    // the bit shifted out of the top forces a subtract
    assign take = r_out[rau_pkg::N_CELLS-1] | ~b_out[rau_pkg::N_CELLS-1];

    for (genvar i = 0; i < rau_pkg::N_CELLS; i++) begin : g_cell
        logic r_in;
        logic q_in;
        logic b_in;
        if (i == 0) begin : g_low
            assign r_in = q_out[rau_pkg::N_CELLS-1];
            assign q_in = take;
            assign b_in = 1'b0;
        end else begin : g_up
            assign r_in = r_out[i-1];
            assign q_in = q_out[i-1];
            assign b_in = b_out[i-1];
        end
        rau_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .take    (take),
            .load_q  (dividend[i*rau_pkg::SLICE_W +: rau_pkg::SLICE_W]),
            .d_slice (divisor[i*rau_pkg::SLICE_W +: rau_pkg::SLICE_W]),
            .r_in    (r_in),
            .q_in    (q_in),
            .b_in    (b_in),
            .r_out   (r_out[i]),
            .q_out   (q_out[i]),
            .b_out   (b_out[i]),
            .q_slice (quotient[i*rau_pkg::SLICE_W +: rau_pkg::SLICE_W])
        );
    end

endmodule

[hdl/rau_checker.sv]
`timescale 1ns / 1ps

module rau_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [63:0]  m_res_num,
    input logic [62:0]         m_res_den,
    input logic                m_compare_true,
    input logic                m_zero_denominator
);

    // hold an unaccepted result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // one item in flight: busy after each input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_compare_true |-> m_res_num == 64'sd0 && m_res_den == 63'd0)
        else $error("compare result carries a fraction");

    a_zd_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_denominator |-> m_res_den == 63'd0)
        else $error("zero denominator flag with nonzero denominator");

    a_zd_num: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_denominator |->
            m_res_num == 64'sd0 || m_res_num == 64'sd1 || m_res_num == -64'sd1)
        else $error("zero denominator numerator not reduced");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic               cmp;
        logic               zden;
    } fraction_t;

    class fraction_scoreboard;
        fraction_t pending[$];
        int        n_mismatch;
        int        n_checked;

        function automatic logic signed [63:0] sext(logic [31:0] raw);
            logic signed [31:0] t;
            t = $signed(raw << (32 - rau_pkg::OPERAND_WIDTH)) >>> (32 - rau_pkg::OPERAND_WIDTH);
            return 64'(t);
        endfunction

        function automatic logic [63:0] absval(logic signed [63:0] x);
            return x < 0 ? 64'(-x) : 64'(x);
        endfunction

        function automatic fraction_t reduce(bit neg, logic [63:0] n, logic [63:0] d);
            fraction_t r;
            logic [63:0] a, b, t;
            a = n;
            b = d;
            while (b != 0) begin
                t = b;
                b = a % b;
                a = t;
            end
            if (a != 0) begin
                n = n / a;
                d = d / a;
            end
            r.num = neg ? -$signed(n) : $signed(n);
            r.den = d[62:0];
            r.cmp = 1'b0;
            r.zden = (d == 0);
            return r;
        endfunction

        function void note_transfer(logic [2:0] cmd, logic [31:0] ra, logic [31:0] rad,
                                    logic [31:0] rb, logic [31:0] rbd, logic [31:0] rw,
                                    logic [2:0] rel);
            logic signed [63:0] an, ad, bn, bd, w, p, q, den, num, s;
            logic [63:0] m;
            bit neg;
            fraction_t r;
            an = sext(ra);
            ad = sext(rad);
            bn = sext(rb);
            bd = sext(rbd);
            w = sext(rw);
            r = '{0, 0, 0, 0};
            case (cmd)
                rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                    p = an * bd;
                    q = ad * bn;
                    if (cmd == rau_pkg::CMD_SUB) q = -q;
                    den = bd * ad;
                    if ((p < 0) == (q < 0)) begin
                        neg = p < 0;
                        m = absval(p) + absval(q);
                    end else begin
                        s = p + q;
                        neg = s < 0;
                        m = absval(s);
                    end
                    r = reduce(neg != (den < 0), m, absval(den));
                end
                rau_pkg::CMD_MUL: begin
                    num = an * bn;
                    den = bd * ad;
                    r = reduce((num < 0) != (den < 0), absval(num), absval(den));
                end
                rau_pkg::CMD_DIV: begin
                    num = an * bd;
                    den = ad * bn;
                    r = reduce((num < 0) != (den < 0), absval(num), absval(den));
                end
                rau_pkg::CMD_CMP: begin
                    p = an * bd;
                    q = bn * ad;
                    case (rel)
                        rau_pkg::REL_LT: r.cmp = p < q;
                        rau_pkg::REL_LE: r.cmp = p <= q;
                        rau_pkg::REL_EQ: r.cmp = p == q;
                        rau_pkg::REL_NE: r.cmp = p != q;
                        rau_pkg::REL_GT: r.cmp = p > q;
                        rau_pkg::REL_GE: r.cmp = p >= q;
                        default: r.cmp = 1'b0;
                    endcase
                end
                rau_pkg::CMD_SET: r = reduce((an < 0) != (ad < 0), absval(an), absval(ad));
                rau_pkg::CMD_MIXED: begin
                    neg = ((w < 0) != (an < 0)) != (ad < 0);
                    m = absval(w) * absval(ad) + absval(an);
                    r = reduce(neg, m, absval(ad));
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(fraction_t got);
            fraction_t want;
            n_checked++;
            if (pending.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result num=%0d", got.num);
                return;
            end
            want = pending.pop_front();
            if (got.num !== want.num || got.den !== want.den || got.cmp !== want.cmp
                    || got.zden !== want.zden) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("mismatch: exp %0d/%0d c%0b z%0b, got %0d/%0d c%0b z%0b",
                             want.num, want.den, want.cmp, want.zden,
                             got.num, got.den, got.cmp, got.zden);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_command = '0;
    logic signed [31:0] s_a_num = '0;
    logic signed [31:0] s_a_den = '0;
    logic signed [31:0] s_b_num = '0;
    logic signed [31:0] s_b_den = '0;
    logic signed [31:0] s_whole = '0;
    logic [2:0]         s_relation = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [63:0] m_res_num;
    logic [62:0]        m_res_den;
    logic               m_compare_true;
    logic               m_zero_denominator;

    fraction_scoreboard sb = new();
    bit calm;
    int n_sent;

    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = -32'sh7fffffff;

    rational_arithmetic_unit_core DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_res_num, m_res_den, m_compare_true, m_zero_denominator});
        if (aresetn && s_valid && s_ready)
            sb.note_transfer(s_command, s_a_num, s_a_den, s_b_num, s_b_den, s_whole,
                             s_relation);
    end

    always @(negedge aclk)
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 21);

    task automatic send(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad, logic [31:0] bn,
                        logic [31:0] bd, logic [31:0] w, logic [2:0] rel);
        while (!calm && $urandom_range(99) < 21) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_a_num <= an;
        s_a_den <= ad;
        s_b_num <= bn;
        s_b_den <= bd;
        s_whole <= w;
        s_relation <= rel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        n_sent++;
    endtask

    function automatic logic [31:0] pick();
        case ($urandom_range(5))
            0: return $urandom_range(20) - 10;
            1: return $urandom_range(1000) - 500;
            2: return $urandom() | 32'h1 ? $urandom() : 0;
            3: return $urandom() % 2 ? MAXV : MINV;
            4: return $urandom();
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int c = 0; c < 8; c++)
            send(3'(c), 3, 4, -5, 6, 2, 3'(c % 6));
        for (int r = 0; r < 8; r++)
            send(rau_pkg::CMD_CMP, 1, 3, 2, 6, 0, 3'(r));
        send(rau_pkg::CMD_SET, 7, 0, 0, 0, 0, rau_pkg::REL_LT);
        send(rau_pkg::CMD_SET, -7, 0, 0, 0, 0, rau_pkg::REL_LT);
        send(rau_pkg::CMD_SET, 0, 0, 0, 0, 0, rau_pkg::REL_LT);
        send(rau_pkg::CMD_ADD, MAXV, MAXV, MAXV, MAXV, 0, rau_pkg::REL_LT);
        send(rau_pkg::CMD_SUB, MINV, 1, MAXV, 1, 0, rau_pkg::REL_LT);
        send(rau_pkg::CMD_MIXED, MINV, MINV, 0, 0, MINV, rau_pkg::REL_LT);
        send(rau_pkg::CMD_MUL, MINV, MAXV, MINV, -1, 0, rau_pkg::REL_LT);
        send(rau_pkg::CMD_DIV, 32'h80000000, 32'hffffffff, 0, 5, 32'h80000000, 3'd7);
        for (int i = 0; i < 1850; i++) begin
            calm = (i >= 600 && i < 800);
            send(3'($urandom_range(7)), pick(), pick(), pick(), pick(), pick(),
                 3'($urandom_range(7)));
        end
        s_valid <= 1'b0;
        calm = 1'b1;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        $display("sent %0d items over all commands and relations, checked %0d results",
                 n_sent, sb.n_checked);
        if (sb.n_mismatch == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end
endmodule
